[rtl/vpq_pkg.sv]
// ----------------------------------------------------------------------------
// vpq_pkg
// Shared types and constants for the virtual interrupt pending queue with
// list register flush.
// ----------------------------------------------------------------------------
package vpq_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int MAX_LIST_REGS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int VIRQ_W   = 24;
    localparam int IDX_W    = 4;
    localparam int LR_W     = 64;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0] LR_COUNT_RST = 5'd4;
    localparam logic [7:0]       LR_PRIO_VAL  = 8'ha0;
    localparam int               LR_PRIO_LSB  = 48;
    localparam int               LR_GROUP1_BIT = 60;
    localparam int               LR_PEND_BIT  = 62;
    localparam int               LR_ACT_BIT   = 63;

    typedef enum logic [CMD_W-1:0] {
        CMD_INJECT = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    // Access request to the list register bank.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [LR_W-1:0]  wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } t_lr_req;

    // List register image for a freshly injected interrupt: group 1,
    // pending, priority 0xa0, hardware bit clear.
    function automatic logic [LR_W-1:0] lr_make(input logic [VIRQ_W-1:0] id);
        logic [LR_W-1:0] v;
        v = LR_W'(id);
        v[LR_GROUP1_BIT] = 1'b1;
        v[LR_PEND_BIT] = 1'b1;
        v[LR_PRIO_LSB +: 8] = LR_PRIO_VAL;
        return v;
    endfunction

endpackage

[rtl/vpq_if.sv]
// ----------------------------------------------------------------------------
// vpq_req_if / vpq_rsp_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface vpq_req_if import vpq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [VIRQ_W-1:0] virq;
    logic [IDX_W-1:0]  lr_index;
    logic [LR_W-1:0]   lr_value;

    modport source (output valid, command, virq, lr_index, lr_value, input ready);
    modport sink   (input valid, command, virq, lr_index, lr_value, output ready);
endinterface

interface vpq_rsp_if import vpq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    pending_left;
    logic [CNT_W-1:0]    moved_count;
    logic [LR_W-1:0]     read_value;

    modport source (output valid, status, pending_left, moved_count, read_value,
                    input ready);
    modport sink   (input valid, status, pending_left, moved_count, read_value,
                    output ready);
endinterface

[rtl/vpq_pend_ram.sv]
// ----------------------------------------------------------------------------
// vpq_pend_ram
// Pending interrupt list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vpq_pend_ram import vpq_pkg::*; #(
    parameter int  DEPTH = PENDING_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [VIRQ_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [VIRQ_W-1:0] o_rd_data
);

    logic [VIRQ_W-1:0] r_mem [DEPTH];
    logic [VIRQ_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/vpq_lr_bank.sv]
// ----------------------------------------------------------------------------
// vpq_lr_bank
// List register bank: storage with a registered read port, per-register
// written and busy flags, and the lowest-free-register search.
// ----------------------------------------------------------------------------
module vpq_lr_bank import vpq_pkg::*; #(
    parameter int MAX_LIST_REGS = MAX_LIST_REGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lr_req          i_req,
    input  logic [CNT_W-1:0] i_lr_limit,
    output logic [LR_W-1:0]  o_rd_data,
    output logic             o_free_any,
    output logic [IDX_W-1:0] o_free_idx
);

    localparam int LA = (MAX_LIST_REGS > 1) ? $clog2(MAX_LIST_REGS) : 1;

    logic [LR_W-1:0]          r_mem [MAX_LIST_REGS];
    logic [LR_W-1:0]          r_rd_data;
    logic                     r_rd_zero;
    logic [MAX_LIST_REGS-1:0] r_vld;
    logic [MAX_LIST_REGS-1:0] r_busy;
    logic [MAX_LIST_REGS-1:0] free_vec;
    logic [CNT_W-1:0]         act_count;
    logic                     wr_ok;
    logic                     rd_ok;
    logic [LA-1:0]            wr_a;
    logic [LA-1:0]            rd_a;

    assign wr_ok = i_req.wr_en && ({1'b0, i_req.wr_idx} < CNT_W'(MAX_LIST_REGS));
    assign rd_ok = {1'b0, i_req.rd_idx} < CNT_W'(MAX_LIST_REGS);
    assign wr_a  = i_req.wr_idx[LA-1:0];
    assign rd_a  = i_req.rd_idx[LA-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_a] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[rd_a];
        end
    end

    // A register never written reads as zero and counts as free if below the limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_busy    <= '0;
            r_rd_zero <= 1'b1;
        end else begin
            if (wr_ok) begin
                r_vld[wr_a]  <= 1'b1;
                r_busy[wr_a] <= i_req.wr_data[LR_PEND_BIT] | i_req.wr_data[LR_ACT_BIT];
            end
            if (i_req.rd_en) begin
                r_rd_zero <= !(rd_ok && r_vld[rd_a]);
            end
        end
    end

    assign o_rd_data = r_rd_zero ? '0 : r_rd_data;

    assign act_count = (i_lr_limit > CNT_W'(MAX_LIST_REGS)) ? CNT_W'(MAX_LIST_REGS)
                                                             : i_lr_limit;

    always_comb begin
        for (int r = 0; r < MAX_LIST_REGS; r++) begin
            free_vec[r] = !r_busy[r] && (CNT_W'(r) < act_count);
        end
    end

    always_comb begin
        o_free_idx = '0;
        for (int r = MAX_LIST_REGS - 1; r >= 0; r--) begin
            if (free_vec[r]) begin
                o_free_idx = IDX_W'(r);
            end
        end
    end

    assign o_free_any = |free_vec;

endmodule

[rtl/virq_pending_queue_lr_flush_top.sv]
// ----------------------------------------------------------------------------
// virq_pending_queue_lr_flush_top
// Ordered pending virtual interrupt list for one vCPU with a bank of list
// registers: inject, flush, list register write and read.
// Sequence: write, read and an inject into a full list go straight to the
//   result state; inject and flush first walk the listed entries, one list
//   memory read per cycle, and an empty list needs no read.
// Throughput: one command at a time; the next word is taken at the edge after
//   the result has moved to the output register.
// Reset: synchronous, active low; empties the list, zeroes the list registers.
// ----------------------------------------------------------------------------
module virq_pending_queue_lr_flush_top import vpq_pkg::*; #(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int MAX_LIST_REGS = MAX_LIST_REGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    vpq_req_if.sink          i_req,
    vpq_rsp_if.source        o_rsp
);

    localparam int PA = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [VIRQ_W-1:0]   r_virq, n_virq;
    logic [CW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_keep, n_keep;
    logic [CW-1:0]       r_moved, n_moved;
    logic                r_dvld, n_dvld;
    logic                r_dup, n_dup;
    t_status             r_status, n_status;
    logic [CNT_W-1:0]    r_cfg;
    logic                r_ov, n_ov;
    t_status             r_o_status, n_o_status;
    logic [CNT_W-1:0]    r_o_left, n_o_left;
    logic [CNT_W-1:0]    r_o_moved, n_o_moved;
    logic [LR_W-1:0]     r_o_rd, n_o_rd;

    logic                acc;
    logic                rd_go;
    logic                pend_wr_en;
    logic [PA-1:0]       pend_wr_addr;
    logic [VIRQ_W-1:0]   pend_wr_data;
    logic [VIRQ_W-1:0]   pend_rd_data;
    t_lr_req             lr_req;
    logic [LR_W-1:0]     lr_rd_data;
    logic                free_any;
    logic [IDX_W-1:0]    free_idx;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign rd_go       = r_ptr < r_total;

    vpq_pend_ram #(.DEPTH(PENDING_DEPTH)) u_pend (
        .i_clk     (i_clk),
        .i_wr_en   (pend_wr_en),
        .i_wr_addr (pend_wr_addr),
        .i_wr_data (pend_wr_data),
        .i_rd_en   ((r_state == S_SCAN || r_state == S_FLUSH) && rd_go),
        .i_rd_addr (r_ptr[PA-1:0]),
        .o_rd_data (pend_rd_data)
    );

    vpq_lr_bank #(.MAX_LIST_REGS(MAX_LIST_REGS)) u_lr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (lr_req),
        .i_lr_limit (r_cfg),
        .o_rd_data  (lr_rd_data),
        .o_free_any (free_any),
        .o_free_idx (free_idx)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_virq     = r_virq;
        n_total    = r_total;
        n_ptr      = r_ptr;
        n_keep     = r_keep;
        n_moved    = r_moved;
        n_dvld     = r_dvld;
        n_dup      = r_dup;
        n_status   = r_status;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_left   = r_o_left;
        n_o_moved  = r_o_moved;
        n_o_rd     = r_o_rd;

        pend_wr_en   = 1'b0;
        pend_wr_addr = r_total[PA-1:0];
        pend_wr_data = r_virq;
        lr_req       = '0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cmd    = t_cmd'(i_req.command);
                    n_virq   = i_req.virq;
                    n_ptr    = '0;
                    n_keep   = '0;
                    n_moved  = '0;
                    n_dvld   = 1'b0;
                    n_dup    = 1'b0;
                    n_status = ST_DONE;
                    n_state  = S_FIN;
                    case (t_cmd'(i_req.command))
                        CMD_INJECT: begin
                            if (r_total >= CW'(PENDING_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_FLUSH: begin
                            n_state = S_FLUSH;
                        end
                        CMD_WRITE: begin
                            lr_req.wr_en   = 1'b1;
                            lr_req.wr_idx  = i_req.lr_index;
                            lr_req.wr_data = i_req.lr_value;
                        end
                        CMD_READ: begin
                            lr_req.rd_en  = 1'b1;
                            lr_req.rd_idx = i_req.lr_index;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read one entry per cycle; compare the word read last cycle.
                n_dvld = rd_go;
                if (rd_go) begin
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_dvld && pend_rd_data == r_virq) begin
                    n_dup = 1'b1;
                end
                if (!rd_go && !r_dvld) begin
                    if (r_dup) begin
                        n_status = ST_DUP;
                    end else begin
                        pend_wr_en = 1'b1;
                        n_total    = r_total + 1'b1;
                    end
                    n_state = S_FIN;
                end
            end
            S_FLUSH: begin
                // Entries that find a free register move out; the rest are
                // written back compacted behind the read pointer.
                n_dvld = rd_go;
                if (rd_go) begin
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_dvld) begin
                    if (free_any) begin
                        lr_req.wr_en   = 1'b1;
                        lr_req.wr_idx  = free_idx;
                        lr_req.wr_data = lr_make(pend_rd_data);
                        n_moved        = r_moved + 1'b1;
                    end else begin
                        pend_wr_en   = 1'b1;
                        pend_wr_addr = r_keep[PA-1:0];
                        pend_wr_data = pend_rd_data;
                        n_keep       = r_keep + 1'b1;
                    end
                end
                if (!rd_go && !r_dvld) begin
                    n_total = r_keep;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_left   = CNT_W'(r_total);
                    n_o_moved  = CNT_W'(r_moved);
                    n_o_rd     = (r_cmd == CMD_READ) ? lr_rd_data : '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_dvld  <= 1'b0;
            r_ov    <= 1'b0;
            r_cfg   <= LR_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_dvld  <= n_dvld;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_virq     <= n_virq;
        r_ptr      <= n_ptr;
        r_keep     <= n_keep;
        r_moved    <= n_moved;
        r_dup      <= n_dup;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_left   <= n_o_left;
        r_o_moved  <= n_o_moved;
        r_o_rd     <= n_o_rd;
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.pending_left = r_o_left;
    assign o_rsp.moved_count  = r_o_moved;
    assign o_rsp.read_value   = r_o_rd;

    // The list never holds more entries than its memory has rows.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(PENDING_DEPTH))
        else $error("pending count exceeds list depth");

    // During a flush each entry either moves out or is kept, never both.
    a_flush_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({pend_wr_en, lr_req.wr_en}))
        else $error("list and register bank written in the same cycle");

    // A command word is taken only once; the block is busy right after it.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !i_req.ready)
        else $error("second command taken while one is in progress");

    // The pending list only changes length at the end of inject or flush.
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_FIN) |=> $stable(r_total))
        else $error("pending count changed outside a list command");

endmodule
